// File: rtl/core/tag_length_deframer_defines.svh
// ----------------------------------------------------------------------------
// tag_length_deframer_defines.svh
// Assertion macros used by the deframer RTL (tld_parser).
// ----------------------------------------------------------------------------
`ifndef TAG_LENGTH_DEFRAMER_DEFINES_SVH
`define TAG_LENGTH_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TLD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define TLD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/tld_pkg.sv
// ----------------------------------------------------------------------------
// tld_pkg
// Types and constants of the tag/length deframer.
// ----------------------------------------------------------------------------
package tld_pkg;

   localparam int unsigned LenWidth  = 31;
   localparam int unsigned AccWidth  = 32;
   localparam int unsigned ByteWidth = 8;

   // Result status codes
   localparam logic [1:0] ST_HEADER = 2'd0;
   localparam logic [1:0] ST_BODY   = 2'd1;
   localparam logic [1:0] ST_ERROR  = 2'd2;

   // Bytes in the length field, counted by the length itself
   localparam logic [AccWidth-1:0] HEADER_LEN = 32'd4;

   // Reset value of the maximum length register
   localparam logic [LenWidth-1:0] MAX_LENGTH_RESET = 31'h4000_0000;

   typedef struct packed {
      logic [1:0]           status;
      logic [ByteWidth-1:0] msg_tag;
      logic [ByteWidth-1:0] body_byte;
      logic [LenWidth-1:0]  body_length;
      logic                 msg_last;
   } tld_result_type;

endpackage

// File: rtl/core/tld_channels.sv
// ----------------------------------------------------------------------------
// tld_channels
// Valid/ready channel interfaces of the deframer.
// ----------------------------------------------------------------------------
interface tld_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface tld_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [7:0]  msg_tag;
   logic [7:0]  body_byte;
   logic [30:0] body_length;
   logic        msg_last;

   modport source (output valid, output status, output msg_tag, output body_byte,
                   output body_length, output msg_last, input ready);
   modport sink   (input valid, input status, input msg_tag, input body_byte,
                   input body_length, input msg_last, output ready);
endinterface

interface tld_csr_if;
   logic        valid;
   logic        ready;
   logic [30:0] max_length;

   modport source (output valid, output max_length, input ready);
   modport sink   (input valid, input max_length, output ready);
endinterface

// File: rtl/core/tld_parser.sv
// ----------------------------------------------------------------------------
// tld_parser
// Framing state machine: absorbs one byte per transfer and forms its result.
// ----------------------------------------------------------------------------
`include "tag_length_deframer_defines.svh"

module tld_parser (
   input  logic                    clock,
   input  logic                    reset,
   tld_csr_if.sink                 csr_chan,
   input  logic                    take,
   input  logic [7:0]              in_byte,
   output tld_pkg::tld_result_type result
);
   import tld_pkg::*;

   // Phase codes
   localparam logic [2:0] PH_TAG  = 3'd0;
   localparam logic [2:0] PH_LEN1 = 3'd1;
   localparam logic [2:0] PH_LEN2 = 3'd2;
   localparam logic [2:0] PH_LEN3 = 3'd3;
   localparam logic [2:0] PH_LEN4 = 3'd4;
   localparam logic [2:0] PH_BODY = 3'd5;

   logic [2:0]           phase_ff, phase_in;
   logic [ByteWidth-1:0] held_tag_ff, held_tag_in;
   logic [AccWidth-1:0]  length_accum_ff, length_accum_in;
   logic [LenWidth-1:0]  bytes_left_ff, bytes_left_in;
   logic [LenWidth-1:0]  body_len_ff, body_len_in;
   logic                 error_ff, error_in;
   logic [LenWidth-1:0]  max_length_ff;

   logic [AccWidth-1:0]  accum_shift;
   logic [AccWidth-1:0]  accum_less_hdr;
   logic                 length_bad;

   assign csr_chan.ready = 1'b1;

   // Length assembly and range check
   assign accum_shift    = {length_accum_ff[AccWidth-ByteWidth-1:0], in_byte};
   assign accum_less_hdr = accum_shift - HEADER_LEN;
   assign length_bad     = (accum_shift < HEADER_LEN) ||
                           (accum_shift > {1'b0, max_length_ff});

   // Next state and result
   always_comb begin
      phase_in        = phase_ff;
      held_tag_in     = held_tag_ff;
      length_accum_in = length_accum_ff;
      bytes_left_in   = bytes_left_ff;
      body_len_in     = body_len_ff;
      error_in        = error_ff;
      result.status      = ST_HEADER;
      result.msg_tag     = held_tag_ff;
      result.body_byte   = '0;
      result.body_length = '0;
      result.msg_last    = 1'b0;

      if (error_ff) begin
         result.status = ST_ERROR;
      end else begin
         unique case (phase_ff) inside
            PH_LEN1, PH_LEN2, PH_LEN3: begin
               length_accum_in = accum_shift;
               phase_in        = phase_ff + 3'd1;
            end
            PH_LEN4: begin
               length_accum_in = accum_shift;
               if (length_bad) begin
                  error_in      = 1'b1;
                  result.status = ST_ERROR;
               end else begin
                  body_len_in        = accum_less_hdr[LenWidth-1:0];
                  bytes_left_in      = accum_less_hdr[LenWidth-1:0];
                  result.body_length = accum_less_hdr[LenWidth-1:0];
                  if (accum_less_hdr[LenWidth-1:0] == '0) begin
                     result.msg_last = 1'b1;
                     phase_in        = PH_TAG;
                  end else begin
                     phase_in = PH_BODY;
                  end
               end
            end
            PH_BODY: begin
               result.status      = ST_BODY;
               result.body_byte   = in_byte;
               result.body_length = body_len_ff;
               bytes_left_in      = bytes_left_ff - 31'd1;
               if (bytes_left_ff == 31'd1) begin
                  result.msg_last = 1'b1;
                  phase_in        = PH_TAG;
               end
            end
            default: begin
               // tag byte; unused codes behave the same
               held_tag_in     = in_byte;
               result.msg_tag  = in_byte;
               length_accum_in = '0;
               bytes_left_in   = '0;
               phase_in        = PH_LEN1;
            end
         endcase
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_TAG;
         held_tag_ff     <= '0;
         length_accum_ff <= '0;
         bytes_left_ff   <= '0;
         body_len_ff     <= '0;
         error_ff        <= 1'b0;
      end else if (take) begin
         phase_ff        <= phase_in;
         held_tag_ff     <= held_tag_in;
         length_accum_ff <= length_accum_in;
         bytes_left_ff   <= bytes_left_in;
         body_len_ff     <= body_len_in;
         error_ff        <= error_in;
      end
   end

   // Maximum length register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= MAX_LENGTH_RESET;
      end else if (csr_chan.valid) begin
         max_length_ff <= csr_chan.max_length;
      end
   end

   // Checks
   `TLD_ASSERT_NEXT(a_error_sticky, clock, reset, error_ff, error_ff,
                    "framing error cleared without reset")
   `TLD_ASSERT_NOW(a_body_has_bytes, clock, reset, phase_ff == PH_BODY,
                   bytes_left_ff != '0, "body phase with no bytes left")
   `TLD_ASSERT_NEXT(a_error_latches, clock, reset, take && result.status == ST_ERROR,
                    error_ff, "error result without latched error")
   `TLD_ASSERT_NOW(a_last_not_error, clock, reset, result.msg_last,
                   result.status != ST_ERROR, "message end flagged on error")

endmodule

// File: rtl/core/tld_out_stage.sv
// ----------------------------------------------------------------------------
// tld_out_stage
// Result register toward the response channel.
// ----------------------------------------------------------------------------
module tld_out_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    take,
   input  tld_pkg::tld_result_type result,
   tld_rsp_if.source               rsp_chan,
   output logic                    can_take
);
   import tld_pkg::*;

   logic           valid_ff;
   tld_result_type data_ff;

   // Room when empty or when the held result leaves this cycle
   assign can_take = !valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (can_take) begin
         valid_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= result;
      end
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.status      = data_ff.status;
   assign rsp_chan.msg_tag     = data_ff.msg_tag;
   assign rsp_chan.body_byte   = data_ff.body_byte;
   assign rsp_chan.body_length = data_ff.body_length;
   assign rsp_chan.msg_last    = data_ff.msg_last;

endmodule

// File: rtl/core/tag_length_deframer.sv
// ----------------------------------------------------------------------------
// tag_length_deframer
// Splits a byte stream into tag / length / body messages.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one stream byte per transfer. Every byte gives exactly
//   one result on rsp_chan: header byte absorbed, body byte, or framing error.
//   Results carry the message tag, the body length once the header is done,
//   and a last flag on the final byte of each message.
//   csr_chan writes max_length; it is always ready. The user must write it
//   only while no byte is in flight; the block itself does not enforce this.
// Timing:
//   One byte per clock sustained while rsp_chan is ready. A result appears
//   on rsp_chan the cycle after its byte transfers, held in the single
//   result register.
// Reset:
//   Synchronous; the parser waits for a tag byte, the error flag is clear,
//   max_length returns to 2^30 and rsp_chan holds no result.
// Stall:
//   While rsp_chan is stalled with a result held, req_chan.ready drops; it
//   rises again in the cycle the held result transfers.
// A bad length (below 4 or above max_length) makes every later result an
// error until reset.
// ----------------------------------------------------------------------------
module tag_length_deframer (
   input  logic      clock,
   input  logic      reset,
   tld_req_if.sink   req_chan,
   tld_rsp_if.source rsp_chan,
   tld_csr_if.sink   csr_chan
);
   import tld_pkg::*;

   logic           can_take;
   logic           take;
   tld_result_type result;

   assign req_chan.ready = can_take;
   assign take           = req_chan.valid && can_take;

   tld_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .take     (take),
      .in_byte  (req_chan.in_byte),
      .result   (result)
   );

   tld_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .result   (result),
      .rsp_chan (rsp_chan),
      .can_take (can_take)
   );

endmodule

// File: tb/tb_tag_length_deframer.sv
// ----------------------------------------------------------------------------
// tb_tag_length_deframer
// Self-checking bench for the tag/length message deframer.
//
// A short table of hand-built messages comes first, with the expected result
// spelled out for the rows that are obvious. Random well-formed messages
// follow under several max_length settings, from 4 up to the largest value.
// The run closes with one bad length, which latches the framing error, and a
// stretch of trailing bytes. A local model of the parser predicts every
// result, and the monitor compares each response transfer field by field.
// ----------------------------------------------------------------------------
module tb_tag_length_deframer;
   timeunit 1ns;
   timeprecision 1ps;

   import tld_pkg::*;

   typedef enum logic [2:0] {
      PH_TAG, PH_LEN1, PH_LEN2, PH_LEN3, PH_LEN4, PH_BODY
   } parse_phase_type;

   // Ways to break the stream at the end of the run
   typedef enum int {BAD_SHORT, BAD_LONG, BAD_TINY_MAX} bad_kind_type;

   typedef struct {
      logic [7:0]     data;
      bit             has_res;
      tld_result_type res;
   } stim_row_type;

   logic clock;
   logic reset;

   tld_req_if req_chan ();
   tld_rsp_if rsp_chan ();
   tld_csr_if csr_chan ();

   tag_length_deframer u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Model state of the parser and its register
   parse_phase_type     parse_phase = PH_TAG;
   logic [7:0]          held_tag    = '0;
   logic [31:0]         len_accum   = '0;
   logic [LenWidth-1:0] body_remain = '0;
   bit                  frame_err   = 1'b0;
   logic [LenWidth-1:0] max_len_reg = MAX_LENGTH_RESET;

   tld_result_type frames_due[$];
   int unsigned    mismatch_count = 0;
   bit             calm_run = 1'b0;

   // Hand-built messages: empty body, two-byte body, one-byte body
   stim_row_type directed_rows[18] = '{
      '{8'h00, 1'b1, '{ST_HEADER, 8'h00, 8'h00, 31'd0, 1'b0}},
      '{8'h00, 1'b1, '{ST_HEADER, 8'h00, 8'h00, 31'd0, 1'b0}},
      '{8'h00, 1'b1, '{ST_HEADER, 8'h00, 8'h00, 31'd0, 1'b0}},
      '{8'h00, 1'b1, '{ST_HEADER, 8'h00, 8'h00, 31'd0, 1'b0}},
      '{8'h04, 1'b1, '{ST_HEADER, 8'h00, 8'h00, 31'd0, 1'b1}},
      '{8'hFF, 1'b1, '{ST_HEADER, 8'hFF, 8'h00, 31'd0, 1'b0}},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h06, 1'b1, '{ST_HEADER, 8'hFF, 8'h00, 31'd2, 1'b0}},
      '{8'h00, 1'b1, '{ST_BODY,   8'hFF, 8'h00, 31'd2, 1'b0}},
      '{8'hFF, 1'b1, '{ST_BODY,   8'hFF, 8'hFF, 31'd2, 1'b1}},
      '{8'h5A, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h05, 1'b0, '0},
      '{8'hA5, 1'b0, '0}
   };

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit
   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Next result of the parser for one stream byte
   function automatic tld_result_type deframe_byte(input logic [7:0] b);
      tld_result_type r;
      r         = '0;
      r.status  = ST_HEADER;
      r.msg_tag = held_tag;
      if (frame_err) begin
         r.status = ST_ERROR;
      end else begin
         case (parse_phase) inside
            PH_LEN1, PH_LEN2, PH_LEN3: begin
               len_accum   = {len_accum[23:0], b};
               parse_phase = parse_phase_type'(parse_phase + 3'd1);
            end
            PH_LEN4: begin
               len_accum = {len_accum[23:0], b};
               if (len_accum < HEADER_LEN || len_accum > {1'b0, max_len_reg}) begin
                  frame_err = 1'b1;
                  r.status  = ST_ERROR;
               end else begin
                  r.body_length = LenWidth'(len_accum - HEADER_LEN);
                  body_remain   = r.body_length;
                  if (r.body_length == '0) begin
                     r.msg_last  = 1'b1;
                     parse_phase = PH_TAG;
                  end else begin
                     parse_phase = PH_BODY;
                  end
               end
            end
            PH_BODY: begin
               r.status      = ST_BODY;
               r.body_byte   = b;
               r.body_length = LenWidth'(len_accum - HEADER_LEN);
               body_remain   = body_remain - 31'd1;
               if (body_remain == '0) begin
                  r.msg_last  = 1'b1;
                  parse_phase = PH_TAG;
               end
            end
            default: begin
               held_tag    = b;
               r.msg_tag   = b;
               len_accum   = '0;
               body_remain = '0;
               parse_phase = PH_LEN1;
            end
         endcase
      end
      return r;
   endfunction

   task automatic flag_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $realtime, what);
      mismatch_count++;
   endtask

   // One byte transfer on the request channel, with an occasional gap first
   task automatic send_byte(input logic [7:0] b, input bit has_res,
                            input tld_result_type res);
      tld_result_type predicted;
      @(negedge clock);
      if (!calm_run && $urandom_range(0, 99) < 4) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.in_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      predicted = deframe_byte(b);
      frames_due.push_back(has_res ? res : predicted);
   endtask

   task automatic stream_idle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
   endtask

   // Hold off until every result has come back
   task automatic wait_drained();
      while (frames_due.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_max_length(input logic [LenWidth-1:0] v);
      @(negedge clock);
      csr_chan.valid      <= 1'b1;
      csr_chan.max_length <= v;
      do @(posedge clock); while (!csr_chan.ready);
      max_len_reg = v;
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // Tag, big-endian length field, then random body bytes
   task automatic send_message(input logic [7:0] tag, input logic [31:0] len_field,
                               input int unsigned body_count);
      send_byte(tag, 1'b0, '0);
      for (int i = 3; i >= 0; i--) send_byte(len_field[8*i +: 8], 1'b0, '0);
      repeat (body_count) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
   endtask

   // Body length that fits the current maximum; mostly short, often at the edge
   function automatic int unsigned pick_body_len();
      logic [31:0] room;
      int unsigned cap;
      int unsigned roll;
      room = {1'b0, max_len_reg} - HEADER_LEN;
      cap  = (room > 40) ? 40 : room;
      roll = $urandom_range(0, 99);
      if (roll < 3 && room >= 300) return $urandom_range(41, 300);
      if (roll < 20 && room <= 40) return room;
      if (roll < 35) return 0;
      return $urandom_range(0, cap);
   endfunction

   // One register setting, then well-formed messages until the budget is spent
   task automatic run_phase(input logic [LenWidth-1:0] max_len, input bit calm,
                            input int unsigned byte_budget);
      int unsigned sent;
      int unsigned n_body;
      stream_idle();
      wait_drained();
      write_max_length(max_len);
      calm_run = calm;
      sent     = 0;
      while (sent < byte_budget) begin
         n_body = pick_body_len();
         send_message(8'($urandom_range(0, 255)), n_body + 4, n_body);
         sent += n_body + 5;
      end
      calm_run = 1'b0;
   endtask

   // Break the stream once; everything after it must report the error
   task automatic run_error_tail();
      bad_kind_type        kind;
      logic [LenWidth-1:0] lim;
      logic [31:0]         bad_len;
      kind = bad_kind_type'($urandom_range(0, 2));
      lim  = LenWidth'(4 + $urandom_range(0, 60));
      case (kind)
         BAD_SHORT: begin
            run_phase(lim, 1'b0, 30);
            bad_len = $urandom_range(0, 3);
         end
         BAD_LONG: begin
            run_phase(lim, 1'b0, 30);
            bad_len = $urandom_range(0, 1) ? {1'b0, lim} + 32'd1
                                           : {1'b1, 31'($urandom)};
         end
         default: begin
            // a maximum below four rejects every length
            stream_idle();
            wait_drained();
            write_max_length(LenWidth'($urandom_range(0, 3)));
            bad_len = $urandom_range(4, 20);
         end
      endcase
      send_message(8'($urandom_range(0, 255)), bad_len, 0);
      repeat (12) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      // a new maximum does not clear the latched error
      stream_idle();
      wait_drained();
      write_max_length(31'h7FFF_FFFF);
      send_message(8'($urandom_range(0, 255)), 32'd8, 4);
   endtask

   // Response side: random back-pressure except in calm stretches
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= calm_run || ($urandom_range(0, 99) >= 9);
      end
   end

   // Compare each response transfer with the oldest expectation
   always @(posedge clock) begin
      tld_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (frames_due.size() == 0) begin
            flag_mismatch("response transfer with nothing expected");
         end else begin
            want = frames_due.pop_front();
            if (rsp_chan.status !== want.status)
               flag_mismatch($sformatf("status %0d, want %0d",
                                       rsp_chan.status, want.status));
            if (rsp_chan.msg_tag !== want.msg_tag)
               flag_mismatch($sformatf("msg_tag %h, want %h",
                                       rsp_chan.msg_tag, want.msg_tag));
            if (rsp_chan.body_byte !== want.body_byte)
               flag_mismatch($sformatf("body_byte %h, want %h",
                                       rsp_chan.body_byte, want.body_byte));
            if (rsp_chan.body_length !== want.body_length)
               flag_mismatch($sformatf("body_length %0d, want %0d",
                                       rsp_chan.body_length, want.body_length));
            if (rsp_chan.msg_last !== want.msg_last)
               flag_mismatch($sformatf("msg_last %b, want %b",
                                       rsp_chan.msg_last, want.msg_last));
         end
      end
   end

   // Stimulus
   initial begin
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.in_byte    = '0;
      csr_chan.valid      = 1'b0;
      csr_chan.max_length = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed messages under the reset maximum
      foreach (directed_rows[i])
         send_byte(directed_rows[i].data, directed_rows[i].has_res, directed_rows[i].res);

      // random messages across register settings
      run_phase(31'd4, 1'b0, 300);
      run_phase(31'h7FFF_FFFF, 1'b1, 380);
      run_phase(LenWidth'(4 + $urandom_range(0, 30)), 1'b0, 380);
      run_phase(LenWidth'($urandom_range(1000, 32'h7FFF_FFFF)), 1'b0, 380);
      run_phase(LenWidth'(4 + $urandom_range(0, 8)), 1'b0, 380);

      run_error_tail();

      stream_idle();
      wait_drained();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/tld_pkg.sv
rtl/core/tld_channels.sv
rtl/core/tld_parser.sv
rtl/core/tld_out_stage.sv
rtl/core/tag_length_deframer.sv
tb/tb_tag_length_deframer.sv
